// ===== rtl/wat_comment_whitespace_filter_defines.svh =====
// assertion macros shared by the comment and whitespace filter rtl
// expects aclk and aresetn in the scope of each use
`ifndef WAT_COMMENT_WHITESPACE_FILTER_DEFINES_SVH
`define WAT_COMMENT_WHITESPACE_FILTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define WCWF_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wcwf assertion failed");

// next-cycle implication, checked out of reset
`define WCWF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wcwf assertion failed");

`endif

// ===== rtl/wcwf_pkg.sv =====
// shared types, character codes and helpers of the comment and whitespace filter
// no dependencies
`timescale 1ns / 1ps

package wcwf_pkg;

    // character codes
    localparam logic [7:0] ChSemi  = 8'h3B;
    localparam logic [7:0] ChOpen  = 8'h28;
    localparam logic [7:0] ChClose = 8'h29;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChCr    = 8'h0D;

    // status codes
    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusUnclosed = 2'd1;
    localparam logic [1:0] StatusTooDeep  = 2'd2;

    // block comment nesting
    localparam int MaxDepth = 255;
    localparam int DepthW   = $clog2(MaxDepth + 1);

    // result queue
    localparam int FifoDepth = 4;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int CntW      = $clog2(FifoDepth + 1);

    // scanner modes
    typedef enum logic [4:0] {
        ModeNormal     = 5'b00001,
        ModeLine       = 5'b00010,
        ModeBlock      = 5'b00100,
        ModeBlockParen = 5'b01000,
        ModeBlockSemi  = 5'b10000
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [1:0] status;
    } result_t;

    // up to two results made by one item
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r1;
        result_t    r0;
    } step_t;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {ChSpace, ChLf, ChTab, ChCr};
    endfunction

    function automatic logic [7:0] as_output(input logic [7:0] c);
        return (c == ChLf) ? ChSpace : c;
    endfunction

endpackage

// ===== rtl/wat_comment_whitespace_filter.sv =====
// Comment and whitespace filter for WebAssembly text, one byte per input item.
//
// Input channel s_*: one source byte per item, s_end_of_stream marks the last.
// Result channel m_*: filtered characters, m_out_last on the final result of a
// stream, m_status flags an unclosed block comment (1) or nesting too deep (2).
// An item yields zero, one or two results, since one char is held as lookahead;
// the end of a stream always yields at least one result.
//
// An accepted item waits in the input register until the result queue has
// room, is then scanned, and its results are written into the queue.
// Throughput: one item per cycle while the four-entry result queue has room
// for two results; the m_ side drains one result per cycle, so items that make
// two results run at the pace of that single output port.
// A stalled receiver fills the queue, then holds the scan stage, then drops
// s_ready; nothing is lost. Reset clears the scanner to normal text with
// nothing held and depth zero, and empties the queue.
// depends on wcwf_pkg, wcwf_scan, wcwf_fifo
`timescale 1ns / 1ps

module wat_comment_whitespace_filter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_end_of_stream,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_out_last,
    output logic [1:0] m_status
);
    import wcwf_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_eos_reg;
    logic       fire;
    logic       room2;
    step_t      step;
    result_t    head;

    // input register, emptied when the scan stage fires and no new byte is taken in
    assign fire    = in_valid_reg && room2;
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_in_char;
            in_eos_reg  <= s_end_of_stream;
        end
    end

    // scanner
    wcwf_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (fire),
        .in_char (in_char_reg),
        .in_eos  (in_eos_reg),
        .step    (step)
    );

    // result queue
    wcwf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step),
        .pop       (m_ready),
        .head      (head),
        .not_empty (m_valid),
        .room2     (room2)
    );

    assign m_out_char = head.ch;
    assign m_out_last = head.last;
    assign m_status   = head.status;

endmodule

// ===== rtl/wcwf_scan.sv =====
// scanner state and per-item filter logic: mode, lookahead char, comment depth
// depends on wcwf_pkg and wat_comment_whitespace_filter_defines.svh
`timescale 1ns / 1ps
`include "wat_comment_whitespace_filter_defines.svh"

module wcwf_scan (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  logic [7:0]      in_char,
    input  logic            in_eos,
    output wcwf_pkg::step_t step
);
    import wcwf_pkg::*;

    scan_mode_t        mode_reg, mode_next;
    logic [7:0]        held_char_reg, held_char_next;
    logic              held_valid_reg, held_valid_next;
    logic [DepthW-1:0] depth_reg, depth_next;

    result_t           res [2];
    logic [1:0]        cnt;

    // one item: mode update, lookahead and up to two results
    always_comb begin
        logic              fresh;
        logic [DepthW-1:0] dec;
        mode_next       = mode_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        depth_next      = depth_reg;
        res[0]          = '0;
        res[1]          = '0;
        cnt             = 2'd0;
        fresh           = 1'b0;
        dec             = depth_reg;

        case (mode_reg)
            ModeLine: begin
                if (in_char == ChLf) begin
                    mode_next       = ModeNormal;
                    held_char_next  = ChLf;
                    held_valid_next = 1'b1;
                end
            end
            ModeNormal: begin
                if (!held_valid_reg) begin
                    fresh = 1'b1;
                end else begin
                    held_valid_next = 1'b0;
                    if (held_char_reg == ChSemi) begin
                        if (in_char == ChSemi) begin
                            mode_next = ModeLine;
                        end else begin
                            res[cnt[0]].ch = ChSemi;
                            cnt            = cnt + 2'd1;
                            fresh          = 1'b1;
                        end
                    end else if (held_char_reg == ChOpen) begin
                        if (in_char == ChSemi) begin
                            mode_next  = ModeBlock;
                            depth_next = DepthW'(1);
                        end else begin
                            res[cnt[0]].ch = ChOpen;
                            cnt            = cnt + 2'd1;
                            fresh          = 1'b1;
                        end
                    end else if (in_char == ChSemi) begin
                        // whitespace right before ';' is dropped
                        fresh = 1'b1;
                    end else if (is_space(in_char)) begin
                        held_char_next  = in_char;
                        held_valid_next = 1'b1;
                    end else begin
                        res[cnt[0]].ch = as_output(held_char_reg);
                        cnt            = cnt + 2'd1;
                        fresh          = 1'b1;
                    end
                end
                // char arriving with nothing held
                if (fresh) begin
                    if (in_char == ChSemi || in_char == ChOpen || is_space(in_char)) begin
                        held_char_next  = in_char;
                        held_valid_next = 1'b1;
                    end else begin
                        res[cnt[0]].ch = in_char;
                        cnt            = cnt + 2'd1;
                    end
                end
            end
            ModeBlock, ModeBlockParen, ModeBlockSemi: begin
                if (mode_reg == ModeBlockParen && in_char == ChSemi) begin
                    // nested open, saturating at the maximum depth
                    if (depth_reg >= DepthW'(MaxDepth)) begin
                        depth_next         = DepthW'(MaxDepth);
                        res[cnt[0]].ch     = 8'd0;
                        res[cnt[0]].status = StatusTooDeep;
                        cnt                = cnt + 2'd1;
                    end else begin
                        depth_next = depth_reg + DepthW'(1);
                    end
                    mode_next = ModeBlock;
                end else if (mode_reg == ModeBlockSemi && in_char == ChClose) begin
                    if (depth_reg != '0) begin
                        dec = depth_reg - DepthW'(1);
                    end
                    depth_next = dec;
                    mode_next  = (dec == '0) ? ModeNormal : ModeBlock;
                end else if (in_char == ChOpen) begin
                    mode_next = ModeBlockParen;
                end else if (in_char == ChSemi) begin
                    mode_next = ModeBlockSemi;
                end else begin
                    mode_next = ModeBlock;
                end
            end
            default: begin
                mode_next = ModeNormal;
            end
        endcase

        // end of stream: flush, mark last result, back to reset state
        if (in_eos) begin
            if (mode_next == ModeLine) begin
                res[cnt[0]].ch = ChSpace;
                cnt            = cnt + 2'd1;
            end else if (mode_next != ModeNormal) begin
                res[cnt[0]].ch     = 8'd0;
                res[cnt[0]].status = StatusUnclosed;
                cnt                = cnt + 2'd1;
            end else if (held_valid_next) begin
                res[cnt[0]].ch = as_output(held_char_next);
                cnt            = cnt + 2'd1;
            end
            if (cnt == 2'd0) begin
                res[0].ch = 8'd0;
                cnt       = 2'd1;
            end
            res[~cnt[0]].last = 1'b1;
            mode_next         = ModeNormal;
            held_char_next    = 8'd0;
            held_valid_next   = 1'b0;
            depth_next        = '0;
        end
    end

    assign step.cnt = step_en ? cnt : 2'd0;
    assign step.r0  = res[0];
    assign step.r1  = res[1];

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= ModeNormal;
            held_char_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            depth_reg      <= '0;
        end else if (step_en) begin
            mode_reg       <= mode_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            depth_reg      <= depth_next;
        end
    end

    `WCWF_ASSERT_NEXT(a_eos_clears, step_en && in_eos,
        mode_reg == ModeNormal && !held_valid_reg && depth_reg == '0)
    `WCWF_ASSERT_IMPLY(a_depth_mode,
        mode_reg == ModeBlock || mode_reg == ModeBlockParen || mode_reg == ModeBlockSemi,
        depth_reg != '0)
    `WCWF_ASSERT_IMPLY(a_eos_result, step_en && in_eos,
        step.cnt != 2'd0 && (step.cnt == 2'd1 ? step.r0.last : (step.r1.last && !step.r0.last)))

endmodule

// ===== rtl/wcwf_fifo.sv =====
// result queue: takes up to two results a cycle, hands out one
// depends on wcwf_pkg and wat_comment_whitespace_filter_defines.svh
`timescale 1ns / 1ps
`include "wat_comment_whitespace_filter_defines.svh"

module wcwf_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  wcwf_pkg::step_t   push,
    input  logic              pop,
    output wcwf_pkg::result_t head,
    output logic              not_empty,
    output logic              room2
);
    import wcwf_pkg::*;

    result_t         mem [FifoDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign room2     = (count_reg <= CntW'(FifoDepth - 2));
    assign head      = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + PtrW'(do_pop);
        count_next  = count_reg + CntW'(push.cnt) - CntW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage writes, second result goes one slot after the first
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_ptr_reg + PtrW'(1)] <= push.r1;
        end
    end

    `WCWF_ASSERT_IMPLY(a_no_overflow, push.cnt != 2'd0,
        (count_reg + CntW'(push.cnt)) <= CntW'(FifoDepth))
    `WCWF_ASSERT_NEXT(a_count_track, 1'b1,
        count_reg == $past(count_reg) + CntW'($past(push.cnt)) - CntW'($past(do_pop)))
    `WCWF_ASSERT_IMPLY(a_ptr_distance, count_reg != CntW'(FifoDepth),
        PtrW'(wr_ptr_reg - rd_ptr_reg) == count_reg[PtrW-1:0])

endmodule

// ===== tb/tb_wat_comment_whitespace_filter.sv =====
// testbench for the comment and whitespace filter: directed and random byte streams,
// a built-in model of the filter predicts every result item, checked in order
// depends on wcwf_pkg and wat_comment_whitespace_filter
`timescale 1ns / 1ps

module tb_wat_comment_whitespace_filter;

    import wcwf_pkg::*;

    localparam int RandomBytes = 760;
    localparam int StallLimit  = 3000;
    localparam int HoldCycles  = 300;
    localparam int HoldAt      = 150;

    typedef enum logic [2:0] {
        LxText,
        LxLine,
        LxBlock,
        LxBlockParen,
        LxBlockSemi
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } src_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_char = 8'h00;
    logic       s_end_of_stream = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_char;
    logic       m_out_last;
    logic [1:0] m_status;

    src_byte_t  feed_q[$];
    src_byte_t  draft_q[$];
    result_t    filtered_q[$];

    int         items_in = 0;
    int         total_items = 0;
    int         errors = 0;
    int         idle_run = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;
    logic       calm;

    // predictor state
    lex_mode_t  lx_mode = LxText;
    logic [7:0] held_ch = 8'h00;
    logic       held_ok = 1'b0;
    int         nest_depth = 0;

    wat_comment_whitespace_filter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_char       (s_in_char),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_out_last      (m_out_last),
        .m_status        (m_status)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // stretch of items with no idling on either side
    assign calm = (items_in >= 300) && (items_in < 700);

    // ---------------------------------------------------------------- predictor

    function automatic logic blank(input logic [7:0] c);
        return (c == ChSpace) || (c == ChLf) || (c == ChTab) || (c == ChCr);
    endfunction

    function automatic logic [7:0] shown(input logic [7:0] c);
        return (c == ChLf) ? ChSpace : c;
    endfunction

    task automatic put(input logic [7:0] ch, input logic [1:0] st);
        filtered_q.push_back('{ch: ch, last: 1'b0, status: st});
    endtask

    // byte in plain text with nothing held back
    task automatic take_plain(input logic [7:0] c);
        if (c == ChSemi || c == ChOpen || blank(c)) begin
            held_ch = c;
            held_ok = 1'b1;
        end else begin
            put(c, StatusOk);
        end
    endtask

    task automatic scan_text(input logic [7:0] c);
        logic [7:0] h;
        if (!held_ok) begin
            take_plain(c);
        end else begin
            h = held_ch;
            held_ok = 1'b0;
            if (h == ChSemi) begin
                if (c == ChSemi) begin
                    lx_mode = LxLine;
                end else begin
                    put(ChSemi, StatusOk);
                    take_plain(c);
                end
            end else if (h == ChOpen) begin
                if (c == ChSemi) begin
                    lx_mode = LxBlock;
                    nest_depth = 1;
                end else begin
                    put(ChOpen, StatusOk);
                    take_plain(c);
                end
            end else if (c == ChSemi) begin
                // whitespace right before a semicolon is dropped
                take_plain(c);
            end else if (blank(c)) begin
                held_ch = c;
                held_ok = 1'b1;
            end else begin
                put(shown(h), StatusOk);
                take_plain(c);
            end
        end
    endtask

    task automatic scan_block(input logic [7:0] c);
        if (lx_mode == LxBlockParen && c == ChSemi) begin
            // another level opens, saturating at the maximum depth
            if (nest_depth >= MaxDepth) begin
                nest_depth = MaxDepth;
                put(8'h00, StatusTooDeep);
            end else begin
                nest_depth++;
            end
            lx_mode = LxBlock;
        end else if (lx_mode == LxBlockSemi && c == ChClose) begin
            if (nest_depth > 0)
                nest_depth--;
            lx_mode = (nest_depth == 0) ? LxText : LxBlock;
        end else if (c == ChOpen) begin
            lx_mode = LxBlockParen;
        end else if (c == ChSemi) begin
            lx_mode = LxBlockSemi;
        end else begin
            lx_mode = LxBlock;
        end
    endtask

    // one accepted byte: append its expected results
    task automatic filter_byte(input logic [7:0] c, input logic eos);
        int      first;
        result_t tail;
        first = filtered_q.size();
        if (lx_mode == LxLine) begin
            if (c == ChLf) begin
                lx_mode = LxText;
                held_ch = ChLf;
                held_ok = 1'b1;
            end
        end else if (lx_mode == LxText) begin
            scan_text(c);
        end else begin
            scan_block(c);
        end
        if (eos) begin
            // flush at the end of the stream
            if (lx_mode == LxLine)
                put(ChSpace, StatusOk);
            else if (lx_mode != LxText)
                put(8'h00, StatusUnclosed);
            else if (held_ok)
                put(shown(held_ch), StatusOk);
            if (filtered_q.size() == first)
                put(8'h00, StatusOk);
            tail = filtered_q.pop_back();
            tail.last = 1'b1;
            filtered_q.push_back(tail);
            lx_mode = LxText;
            held_ch = 8'h00;
            held_ok = 1'b0;
            nest_depth = 0;
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    task automatic add_byte(input logic [7:0] c);
        draft_q.push_back('{ch: c, eos: 1'b0});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // close the stream under construction and queue it for the driver
    task automatic seal();
        src_byte_t b;
        if (draft_q.size() > 0) begin
            b = draft_q.pop_back();
            b.eos = 1'b1;
            draft_q.push_back(b);
            while (draft_q.size() > 0)
                feed_q.push_back(draft_q.pop_front());
        end
    endtask

    function automatic logic [7:0] pick_ink();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return ChSpace;
            1: return ChTab;
            2: return ChCr;
            default: return ChLf;
        endcase
    endfunction

    // one random stream, mostly well-formed comments around random text
    task automatic gen_stream();
        int tokens;
        int open_cnt;
        tokens = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
        open_cnt = 0;
        for (int k = 0; k < tokens; k++) begin
            case ($urandom_range(0, 11))
                0: add_byte(8'($urandom_range(0, 255)));
                1, 2: repeat ($urandom_range(1, 4)) add_byte(pick_ink());
                3: repeat ($urandom_range(1, 3)) add_byte(pick_blank());
                4: add_byte(ChSemi);
                5: add_byte(ChOpen);
                6: add_byte(ChClose);
                7: begin
                    add_byte(ChSemi);
                    add_byte(ChSemi);
                    repeat ($urandom_range(0, 4)) add_byte(pick_ink());
                    if ($urandom_range(0, 4) != 0)
                        add_byte(ChLf);
                end
                8, 9: begin
                    add_byte(ChOpen);
                    add_byte(ChSemi);
                    open_cnt++;
                    repeat ($urandom_range(0, 3)) add_byte(pick_ink());
                end
                10: begin
                    if (open_cnt > 0) begin
                        add_byte(ChSemi);
                        add_byte(ChClose);
                        open_cnt--;
                    end
                end
                default: begin
                    add_byte(pick_blank());
                    add_byte(ChSemi);
                end
            endcase
        end
        // most streams close their block comments
        if ($urandom_range(0, 3) != 0) begin
            while (open_cnt > 0) begin
                add_byte(ChSemi);
                add_byte(ChClose);
                open_cnt--;
            end
        end
        seal();
    endtask

    task automatic gen_random(input int count);
        int base;
        base = feed_q.size();
        while (feed_q.size() - base < count)
            gen_stream();
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge aclk) begin : drive
        logic      go;
        src_byte_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_in_char <= 8'h00;
            s_end_of_stream <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                filter_byte(s_in_char, s_end_of_stream);
                items_in <= items_in + 1;
            end
            if (!s_valid || s_ready) begin
                go = (feed_q.size() > 0) && (calm || $urandom_range(0, 99) >= 34);
                if (go) begin
                    it = feed_q.pop_front();
                    s_valid <= 1'b1;
                    s_in_char <= it.ch;
                    s_end_of_stream <= it.eos;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    always @(posedge aclk) begin : receive
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && items_in >= HoldAt) begin
            // long hold-off so the block backs up into its input
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 34);
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin : monitor
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (filtered_q.size() == 0) begin
                errors++;
                if (errors <= 100)
                    $display("%0t: unexpected item ch=%02h last=%0d st=%0d",
                             $time, m_out_char, m_out_last, m_status);
            end else begin
                want = filtered_q.pop_front();
                if (want.ch !== m_out_char || want.last !== m_out_last ||
                    want.status !== m_status) begin
                    errors++;
                    if (errors <= 100)
                        $display("%0t: mismatch exp %02h/%0d/%0d got %02h/%0d/%0d",
                                 $time, want.ch, want.last, want.status,
                                 m_out_char, m_out_last, m_status);
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= StallLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        // extremes, whitespace collapse, space before semicolon, held newline at end
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("\t \na ;b\n");
        seal();
        // line comment closed by a newline
        add_text(";;x\ny");
        seal();
        // nested block comment, last byte closes it and leaves nothing
        add_text("(;(;;);)");
        seal();
        // end inside a block comment
        add_text("(;");
        seal();
        // end inside a line comment
        add_text(";;z");
        seal();

        gen_random(RandomBytes / 2);

        // nesting one level past the maximum, then unwound
        repeat (MaxDepth + 1) begin
            add_byte(ChOpen);
            add_byte(ChSemi);
        end
        add_byte(8'h71);
        repeat (MaxDepth) begin
            add_byte(ChSemi);
            add_byte(ChClose);
        end
        add_text(" x");
        seal();

        gen_random(RandomBytes / 2);
        total_items = feed_q.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for every item to be taken, then for the last results
        while (items_in < total_items)
            @(posedge aclk);
        while (filtered_q.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
